// ===== rtl/bfd_pkg.sv =====
// shared constants for the box filter downsampler
`default_nettype none

package bfd_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_FACTOR_DEF = 16;

  localparam int PIXEL_W  = 16;
  localparam int MEAN_W   = 16;
  localparam int COL_W    = 12;
  localparam int FACTOR_W = 5;
  localparam int IWIDTH_W = 13;
  localparam int IHEIGHT_W = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [FACTOR_W-1:0]  FACTOR_RST       = 5'd8;
  localparam logic [IWIDTH_W-1:0]  IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [IHEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

endpackage

`default_nettype wire

// ===== rtl/bfd_pix_if.sv =====
// valid/ready channels for pixels in and block means out
`default_nettype none

interface bfd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bfd_pkg::PIXEL_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bfd_blk_if;
  logic                              valid;
  logic                              ready;
  logic signed [bfd_pkg::MEAN_W-1:0] block_mean;
  logic        [bfd_pkg::COL_W-1:0]  out_column;
  logic                              last_of_plane;
  modport source (output valid, output block_mean, output out_column,
                  output last_of_plane, input ready);
  modport sink   (input valid, input block_mean, input out_column,
                  input last_of_plane, output ready);
endinterface

`default_nettype wire

// ===== rtl/box_filter_downsampler_core.sv =====
// box filter downsampler: line memory of block column sums and a serial divider
`default_nettype none

// Averages each factor-by-factor block of a raster-order plane of 16-bit pixels
// and emits one rounded mean (low 16 bits, two's complement) per block, with its
// output column and a flag on the last block of the plane. Blocks cut off at the
// right or bottom edge are completed by repeating the last column or row. Partial
// block sums live in a single-port-per-side line memory with a registered read,
// indexed by output column. A pixel that does not end a block's row segment is
// taken without holding off input; one that ends a segment holds input off for
// the read, add and write back of the line memory entry; one that completes a
// block also holds input off while the restoring divider produces one quotient
// bit per cycle, and while the result waits for the output register to be free.
// The output register lets a finished mean wait while new pixels flow.
// Any register write restarts the plane; no memory clearing pass is needed.
module box_filter_downsampler_core #(
  parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = bfd_pkg::MAX_FACTOR_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bfd_pix_if.sink                               in_px,
  bfd_blk_if.source                             out_blk,
  input  wire logic                             cfg_we,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int CW    = (XW + 1 > bfd_pkg::IWIDTH_W) ? XW + 1 : bfd_pkg::IWIDTH_W;
  localparam int BXW   = (XW > bfd_pkg::COL_W) ? XW : bfd_pkg::COL_W;
  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int CBW   = $clog2(MAX_FACTOR);
  localparam int AW    = 2 * FW;
  localparam int RW    = bfd_pkg::PIXEL_W + CBW;
  localparam int SUM_W = bfd_pkg::PIXEL_W + 2 * CBW;
  localparam int DCW   = $clog2(SUM_W);
  localparam int HW    = bfd_pkg::IHEIGHT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_FIN,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r;

  logic [bfd_pkg::FACTOR_W-1:0]  factor_r;
  logic [bfd_pkg::IWIDTH_W-1:0]  width_r;
  logic [HW-1:0]                 height_r;

  logic [XW-1:0]  x_r;
  logic [HW-1:0]  y_r;
  logic [CBW-1:0] cib_r;
  logic [CBW-1:0] rib_r;
  logic [RW-1:0]  rrs_r;
  logic [XW-1:0]  bx_r;

  // held across the read-modify-write and divide
  logic [RW-1:0]    rrs_fin_r;
  logic [FW-1:0]    krow_r;
  logic [XW-1:0]    bxo_r;
  logic             first_row_r;
  logic             blk_end_r;
  logic             last_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] prod_r;
  logic [SUM_W-1:0] quo_r;
  logic [AW-1:0]    rem_r;
  logic [DCW-1:0]   cnt_r;

  logic [SUM_W-1:0] col_sum_mem [MAX_WIDTH];
  logic [SUM_W-1:0] rd_data_r;

  logic                               out_valid_r;
  logic signed [bfd_pkg::MEAN_W-1:0]  out_mean_r;
  logic [bfd_pkg::COL_W-1:0]          out_col_r;
  logic                               out_last_r;

  // effective register values
  logic [FW-1:0]    eff_f;
  logic [CW-1:0]    eff_w;
  logic [CW-1:0]    width_ext;
  logic [HW-1:0]    eff_h;
  logic [AW-1:0]    area;
  logic [FW-1:0]    f_m1;

  logic             accept;
  logic             last_col;
  logic             last_row;
  logic             col_end;
  logic             row_blk_end;
  logic [FW-1:0]    kcol;
  logic [FW-1:0]    krow;
  logic [RW-1:0]    rrs_sum;
  logic [RW-1:0]    rrs_tot;
  logic [SUM_W-1:0] col_sum;
  logic             mem_rd;
  logic             mem_wr;
  logic [AW:0]      shifted;
  logic             ge;
  logic [AW-1:0]    rem_nxt;
  logic [SUM_W-1:0] quo_nxt;
  logic [BXW-1:0]   bx_wide;
  logic             cfg_hit;
  logic             out_free;

  always_comb begin
    if (factor_r == '0) begin
      eff_f = FW'(1);
    end else if (factor_r > bfd_pkg::FACTOR_W'(MAX_FACTOR)) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(factor_r);
    end
  end

  assign width_ext = CW'(width_r);

  always_comb begin
    if (width_r == '0) begin
      eff_w = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
  end

  assign eff_h = (height_r == '0) ? HW'(1) : height_r;
  assign area  = AW'(eff_f * eff_f);
  assign f_m1  = eff_f - FW'(1);

  assign in_px.ready = (state_r == S_IDLE);
  assign accept      = in_px.valid && in_px.ready;

  assign last_col    = (CW'(x_r) == eff_w - CW'(1));
  assign last_row    = (y_r == eff_h - HW'(1));
  assign col_end     = (FW'(cib_r) == f_m1) || last_col;
  assign row_blk_end = (FW'(rib_r) == f_m1) || last_row;
  assign kcol        = f_m1 - FW'(cib_r);
  assign krow        = f_m1 - FW'(rib_r);

  // edge replication: the last pixel counts for the missing columns too
  assign rrs_sum = rrs_r + RW'(in_px.pixel);
  assign rrs_tot = rrs_sum + RW'(in_px.pixel * kcol);

  assign col_sum = (first_row_r ? '0 : rd_data_r) + SUM_W'(rrs_fin_r);
  assign mem_rd  = accept && col_end;
  assign mem_wr  = (state_r == S_ACC);

  // restoring division step, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign ge      = (shifted >= {1'b0, area});
  assign rem_nxt = ge ? AW'(shifted - {1'b0, area}) : AW'(shifted);
  assign quo_nxt = {quo_r[SUM_W-2:0], ge};

  assign bx_wide  = BXW'(bxo_r);
  assign cfg_hit  = cfg_we && (cfg_index == bfd_pkg::CFG_FACTOR ||
                               cfg_index == bfd_pkg::CFG_IMAGE_WIDTH ||
                               cfg_index == bfd_pkg::CFG_IMAGE_HEIGHT);
  assign out_free = !out_valid_r || out_blk.ready;

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data_r <= col_sum_mem[bx_r];
    end
    if (mem_wr) begin
      col_sum_mem[bxo_r] <= col_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      factor_r    <= bfd_pkg::FACTOR_RST;
      width_r     <= bfd_pkg::IMAGE_WIDTH_RST;
      height_r    <= bfd_pkg::IMAGE_HEIGHT_RST;
      x_r         <= '0;
      y_r         <= '0;
      cib_r       <= '0;
      rib_r       <= '0;
      rrs_r       <= '0;
      bx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_blk.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (col_end) begin
              rrs_fin_r   <= rrs_tot;
              krow_r      <= krow;
              bxo_r       <= bx_r;
              first_row_r <= (rib_r == '0);
              blk_end_r   <= row_blk_end;
              last_r      <= last_col && last_row;
              rrs_r       <= '0;
              cib_r       <= '0;
              bx_r        <= bx_r + XW'(1);
              state_r     <= S_ACC;
            end else begin
              rrs_r <= rrs_sum;
              cib_r <= cib_r + CBW'(1);
            end
            if (last_col) begin
              x_r   <= '0;
              cib_r <= '0;
              bx_r  <= '0;
              rib_r <= row_blk_end ? '0 : rib_r + CBW'(1);
              y_r   <= last_row ? '0 : y_r + HW'(1);
            end else begin
              x_r <= x_r + XW'(1);
            end
          end
        end
        S_ACC: begin
          if (blk_end_r) begin
            sum_r   <= col_sum;
            prod_r  <= SUM_W'(rrs_fin_r * krow_r);
            state_r <= S_FIN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FIN: begin
          // edge replication of rows, then round half up
          quo_r   <= sum_r + prod_r + SUM_W'(area >> 1);
          rem_r   <= '0;
          cnt_r   <= DCW'(SUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - DCW'(1);
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= $signed(quo_r[bfd_pkg::MEAN_W-1:0]);
            out_col_r   <= bx_wide[bfd_pkg::COL_W-1:0];
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          bfd_pkg::CFG_FACTOR: begin
            factor_r <= cfg_data[bfd_pkg::FACTOR_W-1:0];
          end
          bfd_pkg::CFG_IMAGE_WIDTH: begin
            width_r <= cfg_data[bfd_pkg::IWIDTH_W-1:0];
          end
          bfd_pkg::CFG_IMAGE_HEIGHT: begin
            height_r <= cfg_data[HW-1:0];
          end
          default: begin
          end
        endcase
      end
      // any register write restarts the plane
      if (cfg_hit) begin
        x_r   <= '0;
        y_r   <= '0;
        cib_r <= '0;
        rib_r <= '0;
        rrs_r <= '0;
        bx_r  <= '0;
      end
    end
  end

  assign out_blk.valid         = out_valid_r;
  assign out_blk.block_mean    = out_mean_r;
  assign out_blk.out_column    = out_col_r;
  assign out_blk.last_of_plane = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/bfd_checker.sv =====
// port-level checks for the box filter downsampler, bound to the top level
`default_nettype none

module bfd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [bfd_pkg::MEAN_W-1:0]  out_mean,
  input wire logic [bfd_pkg::COL_W-1:0]   out_col,
  input wire logic                        out_last
);

  // a result waiting for its transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mean) && $stable(out_col) && $stable(out_last))
    else $error("result payload changed while stalled");

  // a new mean only appears after the divider has held off input
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a divide phase");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not quiet after reset");

endmodule

bind box_filter_downsampler_core bfd_checker u_bfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_px.ready),
  .out_valid (out_blk.valid),
  .out_ready (out_blk.ready),
  .out_mean  (out_blk.block_mean),
  .out_col   (out_blk.out_column),
  .out_last  (out_blk.last_of_plane)
);

`default_nettype wire
